// File: rtl/fptm_pkg.sv
package fptm_pkg;

  // Table geometry and field widths
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int VA_W              = 48;
  localparam int ENTRY_W           = 64;
  localparam int PFN_W             = 36;
  localparam int PAGE_SHIFT        = 12;
  localparam int MEM_W             = ENTRY_W + 1;   // entry plus page-epoch tag

  // Directory entry flags: valid | write | user
  localparam logic [PAGE_SHIFT-1:0] DIR_FLAGS = 12'h007;
  localparam int BIT_VALID = 0;
  localparam int BIT_LARGE = 7;
  localparam int BIT_LARGE_IN = 12;

  // Page-index remainder unit: bits retired per cycle and step count
  localparam int MOD_DIGITS = 4;
  localparam int MOD_STEPS  = PFN_W / MOD_DIGITS;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  // Operation codes
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_MISALIGNED = 2'd1;
  localparam status_t ST_EXHAUSTED  = 2'd2;

  // Walker sequencer states
  typedef enum logic [2:0] {
    W_CLEAR,
    W_IDLE,
    W_READ,
    W_EVAL,
    W_MOD,
    W_DONE
  } walk_state_t;

  // Table memory port controls
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: rtl/four_level_page_table_mapper_core.sv
// Four-level page table mapper. Each request beat either maps a 4 KiB page
// (op 0: writes the leaf entry, creating missing directory tables from the
// pool) or translates a virtual address (op 1: same walk, returns the leaf's
// address bits 47..12). Tables live in one 65-bit-wide synchronous RAM of
// TABLE_PAGES x 512 entries; pool page 0 is the top level and new pages are
// handed out in order. After reset all TABLE_PAGES*512 entries (32768 at
// the default) are swept to zero with in_stall held high; cfg writes are
// taken during that sweep. One request is worked at a time. A misaligned
// map goes straight to the result. Each upper level reads the RAM and
// checks the entry, then either follows an existing pointer through the
// page-index remainder unit or allocates a new table directly; at the leaf
// a map writes the entry without a read and a translate reads it. The
// result sits in an output register, so a new beat is taken while the
// previous result waits.
module four_level_page_table_mapper_core #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [fptm_pkg::VA_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [fptm_pkg::VA_W-1:0]    in_virt_address,
  input  logic [fptm_pkg::VA_W-1:0]    in_phys_address,
  input  logic [fptm_pkg::ENTRY_W-1:0] in_page_flags,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fptm_pkg::VA_W-1:0]    out_result_address,
  output logic [1:0]                   out_status
);
  import fptm_pkg::*;

  localparam int PW = $clog2(TABLE_PAGES);
  localparam int AW = $clog2(TABLE_PAGES * ENTRIES_PER_TABLE);

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] mem_rdata;
  logic             mod_start;
  logic [PFN_W-1:0] mod_value;
  logic             mod_done;
  logic [PW-1:0]    mod_page;

  // Walk sequencer
  fptm_walker #(.TABLE_PAGES(TABLE_PAGES)) u_walker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_virt_address    (in_virt_address),
    .in_phys_address    (in_phys_address),
    .in_page_flags      (in_page_flags),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_address (out_result_address),
    .out_status         (out_status),
    .mem_ctl            (mem_ctl),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata),
    .mod_start          (mod_start),
    .mod_value          (mod_value),
    .mod_done           (mod_done),
    .mod_page           (mod_page)
  );

  // Table store
  fptm_table_mem #(.TABLE_PAGES(TABLE_PAGES)) u_table_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Pointer-to-page remainder
  fptm_page_mod #(.TABLE_PAGES(TABLE_PAGES)) u_page_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .page  (mod_page)
  );

endmodule

// File: rtl/fptm_table_mem.sv
module fptm_table_mem #(
  parameter int TABLE_PAGES = 64,
  localparam int AW = $clog2(TABLE_PAGES * fptm_pkg::ENTRIES_PER_TABLE)
) (
  input  logic                       clk,
  input  fptm_pkg::mem_ctl_t         ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [fptm_pkg::MEM_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [fptm_pkg::MEM_W-1:0] rdata
);
  import fptm_pkg::*;

  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

  logic [MEM_W-1:0] mem [DEPTH];
  logic [MEM_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fptm_page_mod.sv
module fptm_page_mod #(
  parameter int TABLE_PAGES = 64,
  localparam int PW = $clog2(TABLE_PAGES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fptm_pkg::PFN_W-1:0] value,
  output logic                       done,
  output logic [PW-1:0]              page
);
  import fptm_pkg::*;

  localparam logic [PW:0] MODULUS = (PW+1)'(TABLE_PAGES);

  logic                 busy_r;
  logic                 done_r;
  logic [PFN_W-1:0]     val_r;
  logic [PW:0]          rem_r;
  logic [PW:0]          rem_nxt;
  logic [MOD_CNT_W-1:0] cnt_r;

  // Restoring remainder, MOD_DIGITS bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_DIGITS; i++) begin
      rem_nxt = {rem_nxt[PW-1:0], val_r[PFN_W-1-i]};
      if (rem_nxt >= MODULUS) begin
        rem_nxt = rem_nxt - MODULUS;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      val_r <= val_r << MOD_DIGITS;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + MOD_CNT_W'(1);
    end
  end

  assign done = done_r;
  assign page = rem_r[PW-1:0];

endmodule

// File: rtl/fptm_walker.sv
module fptm_walker #(
  parameter int TABLE_PAGES = 64,
  localparam int PW = $clog2(TABLE_PAGES),
  localparam int NW = $clog2(TABLE_PAGES + 1),
  localparam int AW = $clog2(TABLE_PAGES * fptm_pkg::ENTRIES_PER_TABLE)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [fptm_pkg::VA_W-1:0]    cfg_wr_data,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [fptm_pkg::VA_W-1:0]    in_virt_address,
  input  logic [fptm_pkg::VA_W-1:0]    in_phys_address,
  input  logic [fptm_pkg::ENTRY_W-1:0] in_page_flags,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fptm_pkg::VA_W-1:0]    out_result_address,
  output logic [1:0]                   out_status,
  // table memory
  output fptm_pkg::mem_ctl_t           mem_ctl,
  output logic [AW-1:0]                mem_waddr,
  output logic [fptm_pkg::MEM_W-1:0]   mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  logic [fptm_pkg::MEM_W-1:0]   mem_rdata,
  // page-index remainder unit
  output logic                         mod_start,
  output logic [fptm_pkg::PFN_W-1:0]   mod_value,
  input  logic                         mod_done,
  input  logic [PW-1:0]                mod_page
);
  import fptm_pkg::*;

  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_PAGES * ENTRIES_PER_TABLE - 1);
  localparam logic [NW-1:0] POOL_END = NW'(TABLE_PAGES);

  // Control registers
  walk_state_t  state_r,  state_nxt;
  logic [AW-1:0] clr_r,   clr_nxt;
  logic [NW-1:0] nfp_r,   nfp_nxt;
  logic [PFN_W-1:0] base_r, base_nxt;
  logic         out_valid_r, out_valid_nxt;

  // Item registers
  logic               op_r,     op_nxt;
  logic [VA_W-1:0]    va_r,     va_nxt;
  logic [VA_W-1:0]    pa_r,     pa_nxt;
  logic [ENTRY_W-1:0] flags_r,  flags_nxt;
  logic [1:0]         lvl_r,    lvl_nxt;
  logic [PW-1:0]      page_r,   page_nxt;
  logic [VA_W-1:0]    res_addr_r, res_addr_nxt;
  status_t            res_st_r,   res_st_nxt;
  logic [VA_W-1:0]    out_addr_r, out_addr_nxt;
  status_t            out_st_r,   out_st_nxt;

  // Walk helpers
  logic [IDX_W-1:0]   idx;
  logic               page_live;
  logic               page_live_after;
  logic [ENTRY_W-1:0] entry;
  logic               entry_is_dir;
  logic [PFN_W-1:0]   new_pfn;
  logic [ENTRY_W-1:0] leaf_flags;
  logic               misaligned;

  // Index for the current level
  always_comb begin
    unique case (lvl_r)
      2'd3:    idx = va_r[47:39];
      2'd2:    idx = va_r[38:30];
      2'd1:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  // Entry epoch: a page taken from the pool reads zero until written after it was taken
  assign page_live       = NW'(page_r) <  nfp_r;
  assign page_live_after = NW'(page_r) <= nfp_r;
  assign entry = (page_live && !mem_rdata[ENTRY_W]) ? '0 : mem_rdata[ENTRY_W-1:0];
  assign entry_is_dir = entry[BIT_VALID] && !entry[BIT_LARGE];
  assign new_pfn = base_r + PFN_W'(nfp_r);

  // Large flag moves from bit 12 to bit 7
  always_comb begin
    leaf_flags = flags_r;
    if (flags_r[BIT_LARGE_IN]) begin
      leaf_flags[BIT_LARGE_IN] = 1'b0;
      leaf_flags[BIT_LARGE]    = 1'b1;
    end
  end

  assign misaligned = (in_op == OP_MAP) &&
                      ((|in_virt_address[PAGE_SHIFT-1:0]) ||
                       (|in_phys_address[PAGE_SHIFT-1:0]));

  // Next state and outputs
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    nfp_nxt      = nfp_r;
    base_nxt     = cfg_wr_en ? cfg_wr_data[VA_W-1:PAGE_SHIFT] : base_r;
    op_nxt       = op_r;
    va_nxt       = va_r;
    pa_nxt       = pa_r;
    flags_nxt    = flags_r;
    lvl_nxt      = lvl_r;
    page_nxt     = page_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt = out_addr_r;
    out_st_nxt   = out_st_r;
    in_stall     = 1'b1;
    mem_ctl      = '0;
    mem_waddr    = {page_r, idx};
    mem_wdata    = '0;
    mem_raddr    = {page_r, idx};
    mod_start    = 1'b0;
    mod_value    = entry[VA_W-1:PAGE_SHIFT] - base_r;

    unique case (state_r)
      W_CLEAR: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = clr_r;
        clr_nxt    = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = W_IDLE;
        end
      end

      W_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt    = in_op;
          va_nxt    = in_virt_address;
          pa_nxt    = in_phys_address;
          flags_nxt = in_page_flags;
          lvl_nxt   = 2'd3;
          page_nxt  = '0;
          if (misaligned) begin
            res_addr_nxt = '0;
            res_st_nxt   = ST_MISALIGNED;
            state_nxt    = W_DONE;
          end else begin
            state_nxt = W_READ;
          end
        end
      end

      W_READ: begin
        if (lvl_r == 2'd0 && op_r == OP_MAP) begin
          // leaf write needs no read
          mem_ctl.we   = 1'b1;
          mem_wdata    = {page_live, {16'h0, pa_r} | leaf_flags};
          res_addr_nxt = '0;
          res_st_nxt   = ST_OK;
          state_nxt    = W_DONE;
        end else begin
          mem_ctl.re = 1'b1;
          state_nxt  = W_EVAL;
        end
      end

      W_EVAL: begin
        if (lvl_r == 2'd0) begin
          res_addr_nxt = {entry[VA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
          res_st_nxt   = ST_OK;
          state_nxt    = W_DONE;
        end else if (entry_is_dir) begin
          mod_start = 1'b1;
          state_nxt = W_MOD;
        end else if (nfp_r == POOL_END) begin
          res_addr_nxt = '0;
          res_st_nxt   = ST_EXHAUSTED;
          state_nxt    = W_DONE;
        end else begin
          // take a new table page and point this entry at it
          mem_ctl.we = 1'b1;
          mem_wdata  = {page_live_after, 16'h0, new_pfn, DIR_FLAGS};
          page_nxt   = nfp_r[PW-1:0];
          nfp_nxt    = nfp_r + NW'(1);
          lvl_nxt    = lvl_r - 2'd1;
          state_nxt  = W_READ;
        end
      end

      W_MOD: begin
        if (mod_done) begin
          page_nxt  = mod_page;
          lvl_nxt   = lvl_r - 2'd1;
          state_nxt = W_READ;
        end
      end

      W_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_st_nxt    = res_st_r;
          state_nxt     = W_IDLE;
        end
      end

      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= W_CLEAR;
      clr_r       <= '0;
      nfp_r       <= NW'(1);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nfp_r       <= nfp_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    va_r       <= va_nxt;
    pa_r       <= pa_nxt;
    flags_r    <= flags_nxt;
    lvl_r      <= lvl_nxt;
    page_r     <= page_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_st_r;

  // Pool counter never runs past the pool
  a_nfp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfp_r <= POOL_END)
    else $error("free page counter beyond pool");

  // Pool counter only steps by one
  a_nfp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && nfp_r != $past(nfp_r)) |-> nfp_r == $past(nfp_r) + NW'(1))
    else $error("free page counter jumped");

  // No table write while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == W_IDLE) |-> !mem_ctl.we)
    else $error("table write in idle");

  // An accepted beat starts a walk or a result
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == W_READ || state_r == W_DONE))
    else $error("accepted beat not started");

endmodule
